@@ rtl/core/stl_pkg.sv @@
// Shared types, codes and constants for the Stanley path-tracking steering block.
package stl_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int ADDR_W       = 11;
  localparam int CFG_W        = 21;
  localparam int ANG_W        = 22;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [ANG_W-1:0] PI_Q16      = 22'sd205887;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 22'sd411775;
  localparam logic [16:0]             CORDIC_GAIN = 17'd39797;
  localparam logic [14:0]             MIN_SPEED   = 15'd26;
  localparam logic [CNT_W-1:0]        RETURN_MARGIN = 11'd5;

  localparam logic [2:0] OP_POSE  = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_PATH  = 3'd2;
  localparam logic [2:0] OP_LEAD  = 3'd3;
  localparam logic [2:0] OP_ROUND = 3'd4;
  localparam logic [2:0] OP_LOAD  = 3'd5;

  localparam logic [1:0] KIND_DRIVE  = 2'd0;
  localparam logic [1:0] KIND_WARMUP = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  localparam logic [2:0] REG_GAIN   = 3'd0;
  localparam logic [2:0] REG_LIMIT  = 3'd1;
  localparam logic [2:0] REG_CRUISE = 3'd2;
  localparam logic [2:0] REG_AXLE   = 3'd3;
  localparam logic [2:0] REG_INV_WB = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;
  localparam logic [2:0] REG_LOOK   = 3'd6;
  localparam logic [2:0] REG_WARMUP = 3'd7;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] yaw;
    logic               flag_value;
    logic signed [15:0] speed_value;
    logic               table_select;
    logic [9:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               point_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command_kind;
    logic [14:0]        speed_cmd;
    logic signed [15:0] yaw_rate_cmd;
    logic signed [15:0] steer_cmd;
    logic [9:0]         nearest_index;
  } result_t;

  // arctan(2^-i) in radians Q16
  function automatic logic [16:0] atan_step(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd51472;
      4'd1:    r = 17'd30386;
      4'd2:    r = 17'd16055;
      4'd3:    r = 17'd8150;
      4'd4:    r = 17'd4091;
      4'd5:    r = 17'd2047;
      4'd6:    r = 17'd1024;
      4'd7:    r = 17'd512;
      4'd8:    r = 17'd256;
      4'd9:    r = 17'd128;
      4'd10:   r = 17'd64;
      4'd11:   r = 17'd32;
      4'd12:   r = 17'd16;
      4'd13:   r = 17'd8;
      4'd14:   r = 17'd4;
      default: r = 17'd2;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/stanley_path_tracking_steer.sv @@
// Stanley path-tracking steering controller: waypoint memories, nearest search, steering law.
// Non-pose words complete in the accept cycle; warmup and stop results strobe the next cycle.
// A drive pose runs the nearest-point scan, which reads one waypoint per cycle from the
// memories, then one shared iterative CORDIC (up to three atan2 and three sin/cos) and,
// when needed, a 49-step divider, in sequence.
// One pose at a time; busy is high while it runs. Results cannot be stalled.
// Synchronous reset restores config registers and latches; waypoint memories are not cleared.
module stanley_path_tracking_steer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  stl_pkg::cmd_t          cmd,
  output logic                   done,
  output stl_pkg::result_t       result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [stl_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = 45;
  localparam int NW = 56;
  localparam int AW = stl_pkg::ANG_W;
  localparam int IW = stl_pkg::IDX_W;
  localparam int KW = stl_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE, S_FRONT_MUL, S_FRONT_ADD, S_SCAN, S_CHECK, S_MOD, S_TGT, S_FETCH, S_DIFF,
    S_PATH_ANG, S_PATH_SC, S_CTE_A, S_CTE_B, S_CTE_C, S_GAIN, S_HEAD_ANG, S_HEAD,
    S_STEER_A, S_STEER_B, S_YR_A, S_YR_B, S_YR_C, S_DIV, S_YR_D, S_OUT,
    S_ROT_PREP, S_ATAN_START, S_ATAN_NORM, S_ATAN_PREP, S_CORDIC, S_CORD_FIN
  } state_t;

  function automatic logic signed [AW-1:0] wrap_pi(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = a;
    if (a > stl_pkg::PI_Q16) r = a - stl_pkg::TWO_PI_Q16;
    else if (a < -stl_pkg::PI_Q16) r = a + stl_pkg::TWO_PI_Q16;
    return r;
  endfunction

  // configuration
  logic [15:0] k_gain;
  logic [14:0] steer_lim;
  logic [14:0] cruise;
  logic [20:0] axle_off;
  logic [15:0] inv_wb;
  logic [15:0] st_scale;
  logic [9:0]  look_pts;
  logic [15:0] warm_poses;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_gain     <= 16'd512;
      steer_lim  <= 15'd5734;
      cruise     <= 15'd512;
      axle_off   <= 21'd11141;
      inv_wb     <= 16'd776;
      st_scale   <= 16'd256;
      look_pts   <= 10'd15;
      warm_poses <= 16'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stl_pkg::REG_GAIN:   k_gain     <= cfg_data[15:0];
        stl_pkg::REG_LIMIT:  steer_lim  <= cfg_data[14:0];
        stl_pkg::REG_CRUISE: cruise     <= cfg_data[14:0];
        stl_pkg::REG_AXLE:   axle_off   <= cfg_data[20:0];
        stl_pkg::REG_INV_WB: inv_wb     <= cfg_data[15:0];
        stl_pkg::REG_SCALE:  st_scale   <= cfg_data[15:0];
        stl_pkg::REG_LOOK:   look_pts   <= cfg_data[9:0];
        stl_pkg::REG_WARMUP: warm_poses <= cfg_data[15:0];
      endcase
    end
  end

  state_t state, ret;

  logic          inside_active, stop_latched, round_latched;
  logic [KW-1:0] main_count, inside_count, cnt;
  logic [15:0]   warmup_count;
  logic signed [15:0] lead_speed;

  // waypoint memories: table t entry i at {t, i}
  logic signed [31:0] mem_x [0:2*stl_pkg::MAX_POINTS-1];
  logic signed [31:0] mem_y [0:2*stl_pkg::MAX_POINTS-1];
  logic signed [31:0] rd_x, rd_y;
  logic               mem_we;
  logic [stl_pkg::ADDR_W-1:0] raddr, waddr;

  assign busy   = (state != S_IDLE);
  assign mem_we = start && !busy && (cmd.operation == stl_pkg::OP_LOAD);
  assign waddr  = {cmd.table_select, cmd.point_index};
  assign cnt    = inside_active ? inside_count : main_count;

  // writes happen only while idle and read data is used only during a pose, so no overlap
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[waddr] <= cmd.point_x;
      mem_y[waddr] <= cmd.point_y;
    end
    rd_x <= mem_x[raddr];
    rd_y <= mem_y[raddr];
  end

  // pose working registers
  logic signed [31:0]   px, py;
  logic signed [AW-1:0] yaw8, ang_in, ang_out, cz, base_ang, head;
  logic signed [CW-1:0] cx, cy;
  logic [3:0]           iter;
  logic                 vec, neg;
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        mag;
  logic signed [18:0]   sn, cs;
  logic signed [40:0]   off_c, off_s;
  logic signed [33:0]   fx, fy;
  logic [KW-1:0]        scan_i;
  logic                 rv, v2, v3, found;
  logic [IW-1:0]        idx1, idx2, idx3, n_idx, nxt, tgt, ntgt;
  logic [32:0]          ax, ay;
  logic [65:0]          sqx, sqy;
  logic [66:0]          best;
  logic [KW-1:0]        mdvd, mrem, sum_nl;
  logic [3:0]           mcnt;
  logic [2:0]           fk;
  logic signed [31:0]   wx [0:4];
  logic signed [31:0]   wy [0:4];
  logic signed [32:0]   pdx, pdy, tdx, tdy;
  logic signed [34:0]   dx, dy;
  logic signed [53:0]   p1, p2;
  logic signed [39:0]   cte;
  logic signed [NW-1:0] kc;
  logic [14:0]          spd;
  logic signed [38:0]   sp;
  logic signed [15:0]   steer, yrv;
  logic [30:0]          sw;
  logic signed [50:0]   num;
  logic [48:0]          qd;
  logic [26:0]          drem, dvs;
  logic [5:0]           dcnt;
  logic                 qneg;
  stl_pkg::result_t     res;

  // combinational helpers
  logic [IW-1:0]        fetch_addr, tgt_c, ntgt_c, nxt_c;
  logic [KW-1:0]        t1, n1;
  logic signed [34:0]   diff_x, diff_y, abs_x, abs_y;
  logic [66:0]          sq_sum;
  logic                 dir;
  logic signed [CW-1:0] cx_n, cy_n, xs, ys;
  logic signed [AW-1:0] cz_n, step_a, rot_z, head_c, steer_w;
  logic [NW-1:0]        abs_nx, abs_ny;
  logic signed [NW-1:0] neg_nx, neg_ny;
  logic [KW:0]          msh;
  logic [26:0]          dsh;
  logic                 dge;
  logic signed [32:0]   td0x, td0y;
  logic signed [54:0]   cdiff;
  logic signed [56:0]   kprod;
  logic signed [38:0]   sa, lim39;
  logic [14:0]          spd_c, vmin;
  logic [18:0]          abs_cs;
  logic signed [50:0]   abs_num;

  always_comb begin
    case (fk)
      3'd0:    fetch_addr = n_idx;
      3'd1:    fetch_addr = nxt;
      3'd2:    fetch_addr = tgt;
      3'd3:    fetch_addr = ntgt;
      default: fetch_addr = tgt - 1'b1;
    endcase
    raddr = {inside_active, scan_i[IW-1:0]};
    if (state == S_FETCH) raddr = {inside_active, fetch_addr};

    diff_x = {fx[33], fx} - {{3{rd_x[31]}}, rd_x};
    diff_y = {fy[33], fy} - {{3{rd_y[31]}}, rd_y};
    abs_x  = diff_x[34] ? -diff_x : diff_x;
    abs_y  = diff_y[34] ? -diff_y : diff_y;
    sq_sum = {1'b0, sqx} + {1'b0, sqy};

    // one CORDIC micro-rotation; dir=1 rotates counterclockwise
    dir    = vec ? cy[CW-1] : !cz[AW-1];
    xs     = cx >>> iter;
    ys     = cy >>> iter;
    step_a = $signed({5'd0, stl_pkg::atan_step(iter)});
    if (dir) begin
      cx_n = cx - ys;
      cy_n = cy + xs;
      cz_n = cz - step_a;
    end else begin
      cx_n = cx + ys;
      cy_n = cy - xs;
      cz_n = cz + step_a;
    end
    rot_z  = wrap_pi(ang_in);

    neg_nx = -nx;
    neg_ny = -ny;
    abs_nx = nx[NW-1] ? neg_nx : nx;
    abs_ny = ny[NW-1] ? neg_ny : ny;

    msh = {mrem, mdvd[KW-1]};
    dsh = {drem[25:0], qd[48]};
    dge = (dsh >= dvs);

    n1    = {1'b0, n_idx} + 1'b1;
    nxt_c = (n1 == cnt) ? '0 : n1[IW-1:0];
    if (inside_active && nxt_c == '0) nxt_c = n_idx;

    tgt_c = mrem[IW-1:0];
    if (inside_active && sum_nl >= cnt) tgt_c = IW'(cnt - 1'b1);
    t1     = {1'b0, tgt_c} + 1'b1;
    ntgt_c = (t1 == cnt) ? '0 : t1[IW-1:0];
    if (inside_active && ntgt_c == '0) ntgt_c = tgt_c;

    td0x = {wx[3][31], wx[3]} - {wx[2][31], wx[2]};
    td0y = {wy[3][31], wy[3]} - {wy[2][31], wy[2]};
    if (td0x == '0 && td0y == '0 && tgt != '0) begin
      td0x = {wx[2][31], wx[2]} - {wx[4][31], wx[4]};
      td0y = {wy[2][31], wy[2]} - {wy[4][31], wy[4]};
    end

    cdiff   = {p1[53], p1} - {p2[53], p2};
    kprod   = $signed({1'b0, k_gain}) * cte;
    head_c  = wrap_pi(ang_out - yaw8);
    steer_w = wrap_pi(head + ang_out);
    sa      = sp >>> 11;
    lim39   = $signed({24'd0, steer_lim});

    spd_c = cruise;
    if (round_latched) spd_c = lead_speed[15] ? '0 : lead_speed[14:0];
    vmin  = (spd > stl_pkg::MIN_SPEED) ? spd : stl_pkg::MIN_SPEED;

    abs_cs  = cs[18] ? 19'(-cs) : 19'(cs);
    abs_num = num[50] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      done          <= 1'b0;
      inside_active <= 1'b0;
      stop_latched  <= 1'b0;
      round_latched <= 1'b0;
      main_count    <= '0;
      inside_count  <= '0;
      warmup_count  <= '0;
      lead_speed    <= '0;
      rv            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      found         <= 1'b0;
      scan_i        <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (cmd.operation)
              stl_pkg::OP_POSE: begin
                if (warmup_count < warm_poses) begin
                  warmup_count <= warmup_count + 1'b1;
                  res  <= '{stl_pkg::KIND_WARMUP, '0, '0, '0, '0};
                  done <= 1'b1;
                end else if (stop_latched) begin
                  res  <= '{stl_pkg::KIND_STOP, '0, '0, '0, '0};
                  done <= 1'b1;
                end else if (cnt != '0) begin
                  px     <= cmd.pos_x;
                  py     <= cmd.pos_y;
                  yaw8   <= {{3{cmd.yaw[15]}}, cmd.yaw, 3'b000};
                  ang_in <= {{3{cmd.yaw[15]}}, cmd.yaw, 3'b000};
                  ret    <= S_FRONT_MUL;
                  state  <= S_ROT_PREP;
                end
              end
              stl_pkg::OP_STOP: begin
                stop_latched <= cmd.flag_value;
                if (cmd.flag_value) begin
                  res  <= '{stl_pkg::KIND_STOP, '0, '0, '0, '0};
                  done <= 1'b1;
                end
              end
              stl_pkg::OP_PATH: begin
                if (cmd.flag_value && !inside_active && inside_count != '0)
                  inside_active <= 1'b1;
              end
              stl_pkg::OP_LEAD:  lead_speed <= cmd.speed_value;
              stl_pkg::OP_ROUND: round_latched <= cmd.flag_value;
              stl_pkg::OP_LOAD: begin
                if (cmd.point_last) begin
                  if (cmd.table_select) inside_count <= {1'b0, cmd.point_index} + 1'b1;
                  else main_count <= {1'b0, cmd.point_index} + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_FRONT_MUL: begin
          off_c <= $signed({1'b0, axle_off}) * cs;
          off_s <= $signed({1'b0, axle_off}) * sn;
          state <= S_FRONT_ADD;
        end
        S_FRONT_ADD: begin
          fx     <= {{2{px[31]}}, px} + 34'(off_c >>> 16);
          fy     <= {{2{py[31]}}, py} + 34'(off_s >>> 16);
          scan_i <= '0;
          found  <= 1'b0;
          rv     <= 1'b0;
          v2     <= 1'b0;
          v3     <= 1'b0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_i < cnt) begin
            scan_i <= scan_i + 1'b1;
            idx1   <= scan_i[IW-1:0];
            rv     <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          v2 <= rv;
          if (rv) begin
            ax   <= abs_x[34:2];
            ay   <= abs_y[34:2];
            idx2 <= idx1;
          end
          v3 <= v2;
          if (v2) begin
            sqx  <= ax * ax;
            sqy  <= ay * ay;
            idx3 <= idx2;
          end
          // strict compare keeps the first of equal distances
          if (v3 && (!found || sq_sum < best)) begin
            best  <= sq_sum;
            n_idx <= idx3;
            found <= 1'b1;
          end
          if (scan_i == cnt && !rv && !v2 && !v3) state <= S_CHECK;
        end
        S_CHECK: begin
          if (inside_active && ({1'b0, n_idx} + stl_pkg::RETURN_MARGIN >= cnt)) begin
            inside_active <= 1'b0;
            state         <= S_IDLE;
          end else begin
            nxt    <= nxt_c;
            sum_nl <= {1'b0, n_idx} + {1'b0, look_pts};
            mdvd   <= {1'b0, n_idx} + {1'b0, look_pts};
            mrem   <= '0;
            mcnt   <= '0;
            state  <= S_MOD;
          end
        end
        S_MOD: begin
          mrem <= (msh >= {1'b0, cnt}) ? KW'(msh - {1'b0, cnt}) : msh[KW-1:0];
          mdvd <= {mdvd[KW-2:0], 1'b0};
          mcnt <= mcnt + 1'b1;
          if (mcnt == 4'(KW - 1)) state <= S_TGT;
        end
        S_TGT: begin
          tgt   <= tgt_c;
          ntgt  <= ntgt_c;
          fk    <= '0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (fk != '0) begin
            wx[fk - 1'b1] <= rd_x;
            wy[fk - 1'b1] <= rd_y;
          end
          fk <= fk + 1'b1;
          if (fk == 3'd5) state <= S_DIFF;
        end
        S_DIFF: begin
          pdx   <= {wx[1][31], wx[1]} - {wx[0][31], wx[0]};
          pdy   <= {wy[1][31], wy[1]} - {wy[0][31], wy[0]};
          dx    <= {fx[33], fx} - {{3{wx[0][31]}}, wx[0]};
          dy    <= {fy[33], fy} - {{3{wy[0][31]}}, wy[0]};
          tdx   <= td0x;
          tdy   <= td0y;
          state <= S_PATH_ANG;
        end
        S_PATH_ANG: begin
          if (pdx == '0 && pdy == '0) begin
            cte   <= '0;
            state <= S_GAIN;
          end else begin
            nx    <= {{(NW-33){pdx[32]}}, pdx};
            ny    <= {{(NW-33){pdy[32]}}, pdy};
            ret   <= S_PATH_SC;
            state <= S_ATAN_START;
          end
        end
        S_PATH_SC: begin
          ang_in <= ang_out;
          ret    <= S_CTE_A;
          state  <= S_ROT_PREP;
        end
        S_CTE_A: begin
          p1    <= dx * sn;
          state <= S_CTE_B;
        end
        S_CTE_B: begin
          p2    <= dy * cs;
          state <= S_CTE_C;
        end
        S_CTE_C: begin
          cte   <= {cdiff[54], cdiff[54:16]};
          state <= S_GAIN;
        end
        S_GAIN: begin
          kc    <= kprod[NW-1:0];
          spd   <= spd_c;
          state <= S_HEAD_ANG;
        end
        S_HEAD_ANG: begin
          nx    <= {{(NW-33){tdx[32]}}, tdx};
          ny    <= {{(NW-33){tdy[32]}}, tdy};
          ret   <= S_HEAD;
          state <= S_ATAN_START;
        end
        S_HEAD: begin
          head  <= head_c;
          nx    <= {{(NW-31){1'b0}}, vmin, 16'd0};
          ny    <= kc;
          ret   <= S_STEER_A;
          state <= S_ATAN_START;
        end
        S_STEER_A: begin
          sp    <= steer_w * $signed({1'b0, st_scale});
          state <= S_STEER_B;
        end
        S_STEER_B: begin
          if (sa > lim39) begin
            steer  <= $signed({1'b0, steer_lim});
            ang_in <= {3'b000, steer_lim, 3'b000};
          end else if (sa < -lim39) begin
            steer  <= -$signed({1'b0, steer_lim});
            ang_in <= AW'(-lim39 * 8);
          end else begin
            steer  <= sa[15:0];
            ang_in <= {{3{sa[15]}}, sa[15:0], 3'b000};
          end
          ret   <= S_YR_A;
          state <= S_ROT_PREP;
        end
        S_YR_A: begin
          sw    <= spd * inv_wb;
          state <= S_YR_B;
        end
        S_YR_B: begin
          num   <= $signed({1'b0, sw}) * sn;
          state <= S_YR_C;
        end
        S_YR_C: begin
          if (num == '0) begin
            yrv   <= '0;
            state <= S_OUT;
          end else if (cs == '0) begin
            yrv   <= num[50] ? -16'sd32768 : 16'sd32767;
            state <= S_OUT;
          end else begin
            qd    <= abs_num[48:0];
            dvs   <= {abs_cs, 8'd0};
            drem  <= '0;
            dcnt  <= '0;
            qneg  <= num[50] ^ cs[18];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= dge ? dsh - dvs : dsh;
          qd   <= {qd[47:0], dge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd48) state <= S_YR_D;
        end
        S_YR_D: begin
          if (qneg) yrv <= (qd > 49'd32768) ? -16'sd32768 : -$signed(qd[15:0]);
          else yrv <= (qd > 49'd32767) ? 16'sd32767 : $signed(qd[15:0]);
          state <= S_OUT;
        end
        S_OUT: begin
          res   <= '{stl_pkg::KIND_DRIVE, spd, yrv, steer, n_idx};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_ROT_PREP: begin
          // fold into the right half plane, flip the outputs afterwards
          if (rot_z > stl_pkg::HALF_PI_Q16) begin
            cz  <= rot_z - stl_pkg::PI_Q16;
            neg <= 1'b1;
          end else if (rot_z < -stl_pkg::HALF_PI_Q16) begin
            cz  <= rot_z + stl_pkg::PI_Q16;
            neg <= 1'b1;
          end else begin
            cz  <= rot_z;
            neg <= 1'b0;
          end
          cx    <= {{(CW-17){1'b0}}, stl_pkg::CORDIC_GAIN};
          cy    <= '0;
          iter  <= '0;
          vec   <= 1'b0;
          state <= S_CORDIC;
        end
        S_ATAN_START: begin
          if (abs_nx == '0 && abs_ny == '0) begin
            ang_out <= '0;
            state   <= ret;
          end else begin
            mag   <= (abs_nx > abs_ny) ? abs_nx : abs_ny;
            state <= S_ATAN_NORM;
          end
        end
        S_ATAN_NORM: begin
          // bring the larger magnitude into [2^40, 2^41)
          if (|mag[NW-1:41]) begin
            nx  <= nx >>> 1;
            ny  <= ny >>> 1;
            mag <= mag >> 1;
          end else if (!mag[40]) begin
            nx  <= nx <<< 1;
            ny  <= ny <<< 1;
            mag <= mag << 1;
          end else begin
            state <= S_ATAN_PREP;
          end
        end
        S_ATAN_PREP: begin
          if (nx[NW-1]) begin
            base_ang <= ny[NW-1] ? -stl_pkg::PI_Q16 : stl_pkg::PI_Q16;
            cx       <= neg_nx[CW-1:0];
            cy       <= neg_ny[CW-1:0];
          end else begin
            base_ang <= '0;
            cx       <= nx[CW-1:0];
            cy       <= ny[CW-1:0];
          end
          cz    <= '0;
          iter  <= '0;
          vec   <= 1'b1;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          cx   <= cx_n;
          cy   <= cy_n;
          cz   <= cz_n;
          iter <= iter + 1'b1;
          if (iter == 4'(stl_pkg::CORDIC_STEPS - 1)) state <= S_CORD_FIN;
        end
        S_CORD_FIN: begin
          if (vec) begin
            ang_out <= base_ang + cz;
          end else begin
            sn <= neg ? 19'(-cy) : cy[18:0];
            cs <= neg ? 19'(-cx) : cx[18:0];
          end
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result = res;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.command_kind != stl_pkg::KIND_DRIVE |->
      result.speed_cmd == '0 && result.steer_cmd == '0 &&
      result.yaw_rate_cmd == '0 && result.nearest_index == '0)
    else $error("stop word carries nonzero fields");

  a_steer_limit: assert property (@(posedge clk) disable iff (rst)
    done && result.command_kind == stl_pkg::KIND_DRIVE |->
      result.steer_cmd <= $signed({1'b0, steer_lim}) &&
      result.steer_cmd >= -$signed({1'b0, steer_lim}))
    else $error("steering outside limit");

  a_scan_pipe: assert property (@(posedge clk) disable iff (rst)
    (rv || v2 || v3) |-> state == S_SCAN)
    else $error("scan pipeline active outside scan");

endmodule

@@ test/stanley_path_tracking_steer_test.sv @@
// Self-checking testbench for the Stanley steering block: directed, config and random tests.
module stanley_path_tracking_steer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stl_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam longint PI_A     = 205887;
  localparam longint HALF_A   = 102944;
  localparam longint TWO_A    = 411775;
  localparam longint ARC_HI   = 64'sd2199023255552;  // 2^41
  localparam longint ARC_LO   = 64'sd1099511627776;  // 2^40
  localparam int     SETTLE   = 1500;
  localparam longint MAX_CYC  = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  stanley_path_tracking_steer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // steering predictor state
  longint ctl_reg[8];
  longint wp_x[2048];
  longint wp_y[2048];
  bit     wp_set[2048];
  int     main_len, inside_len;
  bit     inside_on, stop_on, round_on;
  longint warm_seen, lead_spd;
  longint arc_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
  int     reg_w[8] = '{16, 15, 15, 21, 16, 16, 10, 16};

  result_t steer_q[$];
  result_t want;
  int  bad_cnt = 0;
  int  words_sent = 0, poses_sent = 0, results_seen = 0, drives_seen = 0;
  bit  no_gaps = 1'b0;
  longint cycles = 0;

  function automatic longint wrap_angle(input longint a);
    while (a > PI_A) a -= TWO_A;
    while (a < -PI_A) a += TWO_A;
    return a;
  endfunction

  function automatic void rotate_unit(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = 39797;
    y = 0;
    flip = 1'b0;
    z = wrap_angle(a);
    if (z > HALF_A) begin
      z -= PI_A;
      flip = 1'b1;
    end else if (z < -HALF_A) begin
      z += PI_A;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_tab[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint m, ax, ay, base, z, nx;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    base = 0;
    z = 0;
    if (m == 0) return 0;
    while (m >= ARC_HI) begin
      x = x >>> 1; y = y >>> 1; m = m >>> 1;
    end
    while (m < ARC_LO) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    if (x < 0) begin
      base = (y >= 0) ? PI_A : -PI_A;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_tab[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_tab[i];
      end
      x = nx;
    end
    return base + z;
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input longint spd,
                                          input longint yr, input longint st, input int near);
    result_t r;
    r.command_kind  = kind;
    r.speed_cmd     = spd[14:0];
    r.yaw_rate_cmd  = yr[15:0];
    r.steer_cmd     = st[15:0];
    r.nearest_index = near[9:0];
    return r;
  endfunction

  function automatic bit steer_for_word(input cmd_t w, output result_t r);
    int cnt, base, n, nxt, tgt, ntgt, adr;
    longint px, py, yaw8, s, c, fx, fy, ax, ay, d, best, dx, dy, pdx, pdy, ps, pc, cte;
    longint tdx, tdy, head, corr, spd, v, st, lim, num, yr, look;
    r = '0;
    case (w.operation)
      OP_POSE: begin
        if (warm_seen < ctl_reg[REG_WARMUP]) begin
          warm_seen++;
          r = make_result(KIND_WARMUP, 0, 0, 0, 0);
          return 1'b1;
        end
        if (stop_on) begin
          r = make_result(KIND_STOP, 0, 0, 0, 0);
          return 1'b1;
        end
        cnt = inside_on ? inside_len : main_len;
        base = inside_on ? MAX_POINTS : 0;
        if (cnt == 0) return 1'b0;
        px = longint'($signed(w.pos_x));
        py = longint'($signed(w.pos_y));
        yaw8 = longint'($signed(w.yaw)) * 8;
        rotate_unit(yaw8, s, c);
        fx = px + ((ctl_reg[REG_AXLE] * c) >>> 16);
        fy = py + ((ctl_reg[REG_AXLE] * s) >>> 16);
        n = 0;
        best = 0;
        for (int i = 0; i < cnt; i++) begin
          ax = fx - wp_x[base + i];
          ay = fy - wp_y[base + i];
          ax = ((ax < 0) ? -ax : ax) >>> 2;
          ay = ((ay < 0) ? -ay : ay) >>> 2;
          d = ax * ax + ay * ay;
          if (i == 0 || d < best) begin
            best = d;
            n = i;
          end
        end
        if (inside_on && n >= cnt - 5) begin
          inside_on = 1'b0;
          return 1'b0;
        end
        nxt = (n + 1) % cnt;
        if (inside_on && nxt == 0) nxt = n;
        pdx = wp_x[base + nxt] - wp_x[base + n];
        pdy = wp_y[base + nxt] - wp_y[base + n];
        dx = fx - wp_x[base + n];
        dy = fy - wp_y[base + n];
        if (pdx == 0 && pdy == 0) begin
          cte = 0;
        end else begin
          rotate_unit(vector_angle(pdy, pdx), ps, pc);
          cte = (dx * ps - dy * pc) >>> 16;
        end
        look = ctl_reg[REG_LOOK];
        tgt = int'((n + look) % cnt);
        if (inside_on && n + look >= cnt) tgt = cnt - 1;
        ntgt = (tgt + 1) % cnt;
        if (inside_on && ntgt == 0) ntgt = tgt;
        tdx = wp_x[base + ntgt] - wp_x[base + tgt];
        tdy = wp_y[base + ntgt] - wp_y[base + tgt];
        // zero-length lookahead segment: fall back to the one ending at the target
        if (tdx == 0 && tdy == 0 && tgt > 0) begin
          tdx = wp_x[base + tgt] - wp_x[base + tgt - 1];
          tdy = wp_y[base + tgt] - wp_y[base + tgt - 1];
        end
        head = wrap_angle(vector_angle(tdy, tdx) - yaw8);
        spd = ctl_reg[REG_CRUISE];
        if (round_on) spd = (lead_spd > 0) ? lead_spd : 0;
        v = (spd > 26) ? spd : 26;
        corr = vector_angle(ctl_reg[REG_GAIN] * cte, v * 65536);
        st = wrap_angle(head + corr);
        st = ((st * ctl_reg[REG_SCALE]) >>> 8) >>> 3;
        lim = ctl_reg[REG_LIMIT];
        if (st > lim) st = lim;
        if (st < -lim) st = -lim;
        rotate_unit(st * 8, s, c);
        num = spd * ctl_reg[REG_INV_WB] * s;
        if (num == 0) yr = 0;
        else if (c == 0) yr = (num > 0) ? 32767 : -32768;
        else yr = num / (c * 256);
        if (yr > 32767) yr = 32767;
        if (yr < -32768) yr = -32768;
        r = make_result(KIND_DRIVE, spd, yr, st, n);
        return 1'b1;
      end
      OP_STOP: begin
        stop_on = w.flag_value;
        if (w.flag_value) begin
          r = make_result(KIND_STOP, 0, 0, 0, 0);
          return 1'b1;
        end
        return 1'b0;
      end
      OP_PATH: begin
        if (w.flag_value && !inside_on && inside_len > 0) inside_on = 1'b1;
        return 1'b0;
      end
      OP_LEAD: begin
        lead_spd = longint'($signed(w.speed_value));
        return 1'b0;
      end
      OP_ROUND: begin
        round_on = w.flag_value;
        return 1'b0;
      end
      OP_LOAD: begin
        adr = w.table_select * MAX_POINTS + w.point_index;
        wp_x[adr] = longint'($signed(w.point_x));
        wp_y[adr] = longint'($signed(w.point_y));
        wp_set[adr] = 1'b1;
        if (w.point_last) begin
          if (w.table_select) inside_len = w.point_index + 1;
          else main_len = w.point_index + 1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (steer_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected result: kind %0d speed %0d yaw_rate %0d steer %0d near %0d",
                   result.command_kind, result.speed_cmd, $signed(result.yaw_rate_cmd),
                   $signed(result.steer_cmd), result.nearest_index);
      end else begin
        want = steer_q.pop_front();
        if (want.command_kind == KIND_DRIVE) drives_seen++;
        if (result !== want) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("result mismatch: kind %0d/%0d speed %0d/%0d yaw_rate %0d/%0d %s",
                     want.command_kind, result.command_kind, want.speed_cmd,
                     result.speed_cmd, $signed(want.yaw_rate_cmd),
                     $signed(result.yaw_rate_cmd),
                     $sformatf("steer %0d/%0d near %0d/%0d (expected/actual)",
                               $signed(want.steer_cmd), $signed(result.steer_cmd),
                               want.nearest_index, result.nearest_index));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("stanley_path_tracking_steer: mismatch");
      $finish;
    end
  end

  task automatic send_word(input cmd_t w);
    result_t r;
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (steer_for_word(w, r)) steer_q.push_back(r);
    words_sent++;
    if (w.operation == OP_POSE) poses_sent++;
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    ctl_reg[idx] = val & ((64'sd1 <<< reg_w[idx]) - 1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t rand_word(input logic [2:0] op);
    cmd_t w;
    w.operation    = op;
    w.pos_x        = $urandom;
    w.pos_y        = $urandom;
    w.yaw          = $urandom;
    w.flag_value   = $urandom;
    w.speed_value  = $urandom;
    w.table_select = $urandom;
    w.point_index  = $urandom;
    w.point_x      = $urandom;
    w.point_y      = $urandom;
    w.point_last   = 1'b0;
    return w;
  endfunction

  function automatic bit prefix_written(input bit t, input int idx);
    for (int i = 0; i < idx; i++)
      if (!wp_set[t * MAX_POINTS + i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_flag(input logic [2:0] op, input bit f);
    cmd_t w;
    w = rand_word(op);
    w.flag_value = f;
    send_word(w);
  endtask

  task automatic load_path(input bit t, input int n);
    cmd_t w;
    longint x, y;
    x = longint'($urandom_range(400)) * 65536 - 200 * 65536;
    y = longint'($urandom_range(400)) * 65536 - 200 * 65536;
    for (int i = 0; i < n; i++) begin
      w = rand_word(OP_LOAD);
      w.table_select = t;
      w.point_index  = i;
      w.point_x      = x[31:0];
      w.point_y      = y[31:0];
      w.point_last   = (i == n - 1);
      send_word(w);
      // about one point in eight repeats, giving a zero-length segment
      if ($urandom_range(7) != 0) begin
        x += 49152 + longint'($urandom_range(32768));
        y += longint'($urandom_range(65536)) - 32768;
      end
    end
  endtask

  task automatic pose_near(input int pick);
    cmd_t w;
    int cnt, base, i;
    w = rand_word(OP_POSE);
    cnt = inside_on ? inside_len : main_len;
    base = inside_on ? MAX_POINTS : 0;
    if (cnt > 0) begin
      i = (pick >= 0 && pick < cnt) ? pick : $urandom_range(cnt - 1);
      w.pos_x = 32'(wp_x[base + i] + longint'($urandom_range(131072)) - 65536);
      w.pos_y = 32'(wp_y[base + i] + longint'($urandom_range(131072)) - 65536);
      if ($urandom_range(1)) w.yaw = 16'($urandom_range(4000)) - 16'sd2000;
    end
    send_word(w);
  endtask

  task automatic test_directed();
    cmd_t w;
    write_reg(REG_WARMUP, 2);
    repeat (3) pose_near(-1);          // two warmup results, then an empty table
    send_word(rand_word(OP_SPARE_A));
    send_word(rand_word(OP_SPARE_B));
    send_flag(OP_PATH, 1'b1);          // inside table still empty
    load_path(1'b0, 12);
    w = rand_word(OP_LOAD);
    w.table_select = 1'b0;
    w.point_index = 10'd3;
    w.point_x = 32'sh7fffffff;
    w.point_y = 32'sh80000000;
    send_word(w);
    pose_near(0);
    pose_near(3);
    w = rand_word(OP_POSE);
    w.pos_x = 32'sh80000000;
    w.pos_y = 32'sh7fffffff;
    w.yaw = 16'sh8000;
    send_word(w);
    w.pos_x = 32'sh7fffffff;
    w.pos_y = 32'sh80000000;
    w.yaw = 16'sh7fff;
    send_word(w);
    send_flag(OP_STOP, 1'b1);
    pose_near(-1);
    send_flag(OP_STOP, 1'b0);
    w = rand_word(OP_LEAD);
    w.speed_value = 16'sh8000;
    send_word(w);
    send_flag(OP_ROUND, 1'b1);
    pose_near(-1);                     // negative lead speed gives zero speed
    w.speed_value = 16'sh7fff;
    send_word(w);
    pose_near(-1);
    send_flag(OP_ROUND, 1'b0);
    load_path(1'b1, 10);
    send_flag(OP_PATH, 1'b1);
    pose_near(1);
    pose_near(8);                      // near end of inside path: back to main
    pose_near(-1);
  endtask

  task automatic test_warmup_limits();
    settle();
    write_reg(REG_WARMUP, 65535);
    repeat (3) pose_near(-1);
    settle();
    write_reg(REG_WARMUP, 0);
  endtask

  task automatic set_config(input int kind);
    longint v[8];
    case (kind)
      1: v = '{65535, 25736, 32767, 1048576, 65535, 65535, 1023, 0};
      2: v = '{0, 0, 0, 0, 1, 0, 0, 0};
      default: begin
        v[0] = $urandom_range(2048);
        v[1] = $urandom_range(25736);
        v[2] = $urandom_range(4096);
        v[3] = $urandom_range(1048576);
        v[4] = $urandom_range(1, 2048);
        v[5] = $urandom_range(1024);
        v[6] = $urandom_range(1023);
        v[7] = $urandom_range(1);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
  endtask

  task automatic run_random(input int n);
    cmd_t w;
    int r;
    load_path(1'b0, $urandom_range(6, 30));
    load_path(1'b1, $urandom_range(6, 16));
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      r = $urandom_range(99);
      if (r < 55) pose_near(-1);
      else if (r < 62) send_word(rand_word(OP_POSE));
      else if (r < 69) begin
        w = rand_word(OP_LOAD);
        w.point_last = $urandom_range(1) && prefix_written(w.table_select, w.point_index);
        send_word(w);
      end else if (r < 74) send_flag(OP_STOP, $urandom_range(9) < 3);
      else if (r < 82) send_flag(OP_PATH, $urandom_range(3) != 0);
      else if (r < 88) send_word(rand_word(OP_LEAD));
      else if (r < 95) send_flag(OP_ROUND, $urandom_range(1));
      else send_word(rand_word($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B));
    end
    send_flag(OP_STOP, 1'b0);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      settle();
      set_config(p);
      no_gaps = (p == 2);
      run_random(40);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) ctl_reg[i] = 0;
    ctl_reg[REG_GAIN] = 512;   ctl_reg[REG_LIMIT] = 5734; ctl_reg[REG_CRUISE] = 512;
    ctl_reg[REG_AXLE] = 11141; ctl_reg[REG_INV_WB] = 776; ctl_reg[REG_SCALE] = 256;
    ctl_reg[REG_LOOK] = 15;    ctl_reg[REG_WARMUP] = 10;
    for (int i = 0; i < 2048; i++) begin
      wp_x[i] = 0; wp_y[i] = 0; wp_set[i] = 1'b0;
    end
    main_len = 0; inside_len = 0;
    inside_on = 1'b0; stop_on = 1'b0; round_on = 1'b0;
    warm_seen = 0; lead_spd = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_warmup_limits();
    test_random_phases();
    drain();
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d words (%0d poses) over four register settings and extremes",
             words_sent, poses_sent);
    $display("checked %0d results, %0d drive commands, %0d mismatches",
             results_seen, drives_seen, bad_cnt);
    if (bad_cnt == 0 && steer_q.size() == 0) begin
      $display("stanley_path_tracking_steer: match");
    end else begin
      $display("stanley_path_tracking_steer: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/stl_pkg.sv
rtl/core/stanley_path_tracking_steer.sv
test/stanley_path_tracking_steer_test.sv
